/* src/nssd_pkg.sv */
// Package: display mode codes, segment patterns and divider reciprocals for the digit encoder.
package nssd_pkg;

	typedef logic [1:0] mode_t;
	typedef logic [6:0] seg_t;

	localparam mode_t MODE_UNSIGNED = 2'd0;
	localparam mode_t MODE_SIGNED   = 2'd1;
	localparam mode_t MODE_HEX      = 2'd2;

	localparam seg_t PAT_BLANK = 7'h00;
	localparam seg_t PAT_MINUS = 7'h40;
	localparam seg_t PAT_E     = 7'h79;

	// floor(n / D) == (n * M) >> S for every 16-bit n
	localparam logic [15:0] RECIP_10    = 16'd52429;  // S = 19
	localparam logic [16:0] RECIP_100   = 17'd83887;  // S = 23
	localparam logic [16:0] RECIP_1000  = 17'd67109;  // S = 26
	localparam logic [16:0] RECIP_10000 = 17'd107375; // S = 30

	function automatic seg_t seg_of(logic [3:0] d);
		seg_t p;
		unique case (d)
			4'h0: p = 7'h3F;
			4'h1: p = 7'h06;
			4'h2: p = 7'h5B;
			4'h3: p = 7'h4F;
			4'h4: p = 7'h66;
			4'h5: p = 7'h6D;
			4'h6: p = 7'h7D;
			4'h7: p = 7'h07;
			4'h8: p = 7'h7F;
			4'h9: p = 7'h6F;
			4'hA: p = 7'h77;
			4'hB: p = 7'h7C;
			4'hC: p = 7'h39;
			4'hD: p = 7'h5E;
			4'hE: p = 7'h79;
			4'hF: p = 7'h71;
		endcase
		return p;
	endfunction

endpackage

/* src/number_to_seven_segment_digits.sv */
// Top level: 16-bit value to four seven-segment patterns, decimal or hex.
// Usage
//   Request channel: drive value and pulse start; a request is taken at every
//   rising edge with start high and busy low. busy never rises, so a new
//   request may be issued every cycle.
//   Result channel: strobe is high for one cycle while seg_thousands,
//   seg_hundreds, seg_tens, seg_ones and out_of_range hold the result. The
//   receiver cannot stall; each result is offered exactly once.
//   Config channel: cfg_data is written into the display mode register when
//   cfg_valid and cfg_ready are both high; cfg_ready is always high. Write it
//   only while no request is in flight.
// Throughput
//   One request per cycle, set by the three-stage pipeline: input register,
//   reciprocal multipliers for /10, /100, /1000, /10000, then digit
//   extraction, blanking and segment lookup into the result register; strobe
//   rises once the request has passed all three registers.
// Reset
//   arst_n low clears the pipeline valid bits and sets the mode to unsigned
//   decimal; requests in flight are dropped.
module number_to_seven_segment_digits #(
	parameter int UNSIGNED_LIMIT = 9999
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [15:0]         value,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  nssd_pkg::mode_t     cfg_data,
	output logic                strobe,
	output nssd_pkg::seg_t      seg_thousands,
	output nssd_pkg::seg_t      seg_hundreds,
	output nssd_pkg::seg_t      seg_tens,
	output nssd_pkg::seg_t      seg_ones,
	output logic                out_of_range
);
	import nssd_pkg::*;

	localparam logic [15:0] LIMIT = 16'(UNSIGNED_LIMIT);

	// Low digit of n given q = n / 10: n - 10 * q, built from shifts.
	function automatic logic [3:0] low_digit(logic [15:0] n, logic [15:0] q);
		logic [15:0] r;
		r = n - ((q << 3) + (q << 1));
		return r[3:0];
	endfunction

	mode_t mode_q;

	// Stage 1: captured request.
	logic        valid_s1;
	logic [15:0] value_s1;
	mode_t       mode_s1;

	// Stage 2: magnitude and its quotients.
	logic        valid_s2;
	mode_t       mode_s2;
	logic        neg_s2;
	logic        over_s2;
	logic [7:0]  byte_s2;
	logic [15:0] mag_s2;
	logic [12:0] q10_s2;
	logic [9:0]  q100_s2;
	logic [6:0]  q1000_s2;
	logic [2:0]  q10000_s2;

	logic        neg;
	logic [15:0] mag;
	logic [31:0] p10;
	logic [32:0] p100, p1000, p10000;

	logic [3:0]  d0, d1, d2, d3;
	seg_t        th_d, hu_d, te_d, on_d;
	logic        oor_d;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UNSIGNED;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// Stage 1: take the request along with the mode it was issued under.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			value_s1 <= value;
			mode_s1  <= mode_q;
		end
	end

	// Negate in signed mode only; 0x8000 maps onto itself, i.e. 32768.
	assign neg    = (mode_s1 == MODE_SIGNED) && value_s1[15];
	assign mag    = neg ? (~value_s1 + 16'd1) : value_s1;
	assign p10    = 32'(mag) * 32'(RECIP_10);
	assign p100   = 33'(mag) * 33'(RECIP_100);
	assign p1000  = 33'(mag) * 33'(RECIP_1000);
	assign p10000 = 33'(mag) * 33'(RECIP_10000);

	// Stage 2: hold the quotients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mode_s2   <= mode_s1;
			neg_s2    <= neg;
			over_s2   <= value_s1 > LIMIT;
			byte_s2   <= value_s1[7:0];
			mag_s2    <= mag;
			q10_s2    <= p10[31:19];
			q100_s2   <= p100[32:23];
			q1000_s2  <= p1000[32:26];
			q10000_s2 <= p10000[32:30];
		end
	end

	// Stage 3: peel off the four decimal digits and pick the patterns.
	assign d0 = low_digit(mag_s2, 16'(q10_s2));
	assign d1 = low_digit(16'(q10_s2), 16'(q100_s2));
	assign d2 = low_digit(16'(q100_s2), 16'(q1000_s2));
	assign d3 = low_digit(16'(q1000_s2), 16'(q10000_s2));

	always_comb begin
		th_d  = PAT_BLANK;
		hu_d  = PAT_BLANK;
		te_d  = PAT_BLANK;
		on_d  = PAT_BLANK;
		oor_d = 1'b0;
		case (mode_s2)
			MODE_UNSIGNED: begin
				if (over_s2) begin
					th_d  = PAT_E;
					hu_d  = PAT_E;
					te_d  = PAT_E;
					on_d  = PAT_E;
					oor_d = 1'b1;
				end else begin
					th_d = seg_of(d3);
					hu_d = seg_of(d2);
					te_d = seg_of(d1);
					on_d = seg_of(d0);
				end
			end
			MODE_SIGNED: begin
				on_d = seg_of(d0);
				if (neg_s2) begin
					th_d = PAT_MINUS;
					hu_d = seg_of(d2);
					te_d = seg_of(d1);
				end else begin
					// blank leading positions while the value is short
					if (q1000_s2 != 7'd0) th_d = seg_of(d3);
					if (q100_s2 != 10'd0) hu_d = seg_of(d2);
					if (q10_s2 != 13'd0)  te_d = seg_of(d1);
				end
			end
			MODE_HEX: begin
				hu_d = seg_of(byte_s2[7:4]);
				te_d = seg_of(byte_s2[3:0]);
			end
			default: begin
				// unused mode: leave every position blank
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			seg_thousands <= th_d;
			seg_hundreds  <= hu_d;
			seg_tens      <= te_d;
			seg_ones      <= on_d;
			out_of_range  <= oor_d;
		end
	end

	// Every accepted request comes out on strobe once it has passed the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 strobe)
		else $error("request did not produce a result after three cycles");

	// No rising strobe without a matching earlier request.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> $past(start && !busy, 3))
		else $error("result strobe without a matching request");

	// The error flag always comes with the error pattern in all four positions.
	a_err_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && out_of_range) |-> (seg_thousands == PAT_E && seg_hundreds == PAT_E
			&& seg_tens == PAT_E && seg_ones == PAT_E))
		else $error("out_of_range without the error pattern");

	// A minus sign leads only in signed mode and never with the error flag.
	a_minus_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && neg_s2) |-> (mode_s2 == MODE_SIGNED && !oor_d))
		else $error("negative magnitude outside signed mode");

endmodule

/* verif/number_to_seven_segment_digits_tb.sv */
// Testbench for the digit encoder: directed table, then random requests checked by a predictor.
`timescale 1ns / 100ps

module number_to_seven_segment_digits_tb;
	import nssd_pkg::*;

	localparam int UNSIGNED_LIMIT = 9999;
	localparam mode_t MODE_BLANK = 2'd3;  // unused code: all positions blank
	localparam int PIPE_SETTLE = 4;       // cycles to let the pipeline empty
	localparam int WATCHDOG_LIMIT = 2000; // cycles with no handshake at all
	localparam int REPORT_LIMIT = 10;
	localparam int PROBE_COUNT = 22;

	// hex digit to segment pattern, bit 0 = segment a
	localparam seg_t DIGIT_SEGS [16] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
		7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
	};

	typedef struct packed {
		seg_t th;
		seg_t hu;
		seg_t te;
		seg_t on;
		logic oor;
	} digits_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] value;
		digits_t     want;
	} digits_req_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] value;
		logic        pinned;  // want is typed in, not predicted
		digits_t     want;
	} probe_row_t;

	// Directed table: reset mode first, then each mode with its edge values.
	localparam probe_row_t PROBES [PROBE_COUNT] = '{
		'{MODE_UNSIGNED, 16'd0,     1'b1, '{7'h3F, 7'h3F, 7'h3F, 7'h3F, 1'b0}},
		'{MODE_UNSIGNED, 16'd9999,  1'b1, '{7'h6F, 7'h6F, 7'h6F, 7'h6F, 1'b0}},
		'{MODE_UNSIGNED, 16'd10000, 1'b1, '{7'h79, 7'h79, 7'h79, 7'h79, 1'b1}},
		'{MODE_UNSIGNED, 16'hFFFF,  1'b1, '{7'h79, 7'h79, 7'h79, 7'h79, 1'b1}},
		'{MODE_UNSIGNED, 16'd1234,  1'b0, '0},
		'{MODE_UNSIGNED, 16'd8,     1'b0, '0},
		'{MODE_SIGNED,   16'd0,     1'b1, '{7'h00, 7'h00, 7'h00, 7'h3F, 1'b0}},
		'{MODE_SIGNED,   16'd7,     1'b0, '0},
		'{MODE_SIGNED,   16'd99,    1'b0, '0},
		'{MODE_SIGNED,   16'd999,   1'b0, '0},
		'{MODE_SIGNED,   16'd10000, 1'b0, '0},
		'{MODE_SIGNED,   16'h7FFF,  1'b0, '0},
		'{MODE_SIGNED,   16'hFFFF,  1'b1, '{7'h40, 7'h3F, 7'h3F, 7'h06, 1'b0}},
		'{MODE_SIGNED,   16'h8000,  1'b1, '{7'h40, 7'h07, 7'h7D, 7'h7F, 1'b0}},
		'{MODE_SIGNED,   16'hFC18,  1'b0, '0},
		'{MODE_HEX,      16'h0000,  1'b1, '{7'h00, 7'h3F, 7'h3F, 7'h00, 1'b0}},
		'{MODE_HEX,      16'hFFFF,  1'b1, '{7'h00, 7'h71, 7'h71, 7'h00, 1'b0}},
		'{MODE_HEX,      16'h12AB,  1'b0, '0},
		'{MODE_HEX,      16'hFF5A,  1'b0, '0},
		'{MODE_HEX,      16'd10000, 1'b0, '0},
		'{MODE_BLANK,    16'd0,     1'b1, '{7'h00, 7'h00, 7'h00, 7'h00, 1'b0}},
		'{MODE_BLANK,    16'hFFFF,  1'b1, '{7'h00, 7'h00, 7'h00, 7'h00, 1'b0}}
	};

	// sender idle percentage per group of random segments
	localparam int IDLE_PCT [5] = '{0, 58, 0, 21, 58};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] value;
	logic        cfg_valid;
	logic        cfg_ready;
	mode_t       cfg_data;
	logic        strobe;
	seg_t        seg_thousands;
	seg_t        seg_hundreds;
	seg_t        seg_tens;
	seg_t        seg_ones;
	logic        out_of_range;

	number_to_seven_segment_digits dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.strobe        (strobe),
		.seg_thousands (seg_thousands),
		.seg_hundreds  (seg_hundreds),
		.seg_tens      (seg_tens),
		.seg_ones      (seg_ones),
		.out_of_range  (out_of_range)
	);

	// Expected displays, oldest first, one per accepted request.
	digits_req_t pending_digits [$];

	mode_t   shown_mode;      // our copy of the display mode register
	logic    pin_valid;       // driver hands a typed-in expectation to the monitor
	digits_t pin_digits;
	int      requests_sent;
	int      results_checked;
	int      mode_writes;
	int      fault_count;
	int      quiet_cycles;

	// Work out the four patterns and the flag for one value in one mode.
	function automatic digits_t encode_digits(mode_t m, logic [15:0] v);
		digits_t d;
		int      n;
		int      mag;
		d = '0;
		n = int'(v);
		case (m)
			MODE_UNSIGNED: begin
				if (n > UNSIGNED_LIMIT) begin
					d.th = PAT_E;
					d.hu = PAT_E;
					d.te = PAT_E;
					d.on = PAT_E;
					d.oor = 1'b1;
				end else begin
					d.th = DIGIT_SEGS[(n / 1000) % 10];
					d.hu = DIGIT_SEGS[(n / 100) % 10];
					d.te = DIGIT_SEGS[(n / 10) % 10];
					d.on = DIGIT_SEGS[n % 10];
				end
			end
			MODE_SIGNED: begin
				// -32768 keeps its full magnitude 32768
				mag = v[15] ? 65536 - n : n;
				if (v[15]) begin
					d.th = PAT_MINUS;
					d.hu = DIGIT_SEGS[(mag / 100) % 10];
					d.te = DIGIT_SEGS[(mag / 10) % 10];
				end else begin
					// blank leading positions of small positives
					if (mag >= 1000) d.th = DIGIT_SEGS[(mag / 1000) % 10];
					if (mag >= 100) d.hu = DIGIT_SEGS[(mag / 100) % 10];
					if (mag >= 10) d.te = DIGIT_SEGS[(mag / 10) % 10];
				end
				d.on = DIGIT_SEGS[mag % 10];
			end
			MODE_HEX: begin
				d.hu = DIGIT_SEGS[v[7:4]];
				d.te = DIGIT_SEGS[v[3:0]];
			end
			default: begin
			end
		endcase
		return d;
	endfunction

	// Pick a value, weighted toward the decimal boundaries and the sign edges.
	function automatic logic [15:0] pick_value();
		logic [15:0] t;
		case ($urandom_range(7))
			0: t = 16'($urandom);
			1: t = 16'($urandom_range(UNSIGNED_LIMIT));
			2: t = 16'($urandom_range(9990, 10010));
			3: t = 16'($urandom_range(0, 120));
			4: t = 16'($urandom_range(0, 1100));
			5: begin
				t = 16'($urandom_range(1, 1100));
				t = -t;
			end
			6: t = 16'h7FF0 + 16'($urandom_range(31));
			default: t = 16'($urandom);
		endcase
		return t;
	endfunction

	// Clock: 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Monitor: record accepted requests, check each strobed result against the oldest one.
	always @(posedge clk or negedge arst_n) begin
		digits_req_t exp_req;
		digits_t     got;
		logic        moved;
		if (!arst_n) begin
			shown_mode <= MODE_UNSIGNED;
			quiet_cycles <= 0;
		end else begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				shown_mode <= cfg_data;
				mode_writes <= mode_writes + 1;
				moved = 1'b1;
			end
			if (start && !busy) begin
				exp_req.mode = shown_mode;
				exp_req.value = value;
				exp_req.want = pin_valid ? pin_digits : encode_digits(shown_mode, value);
				pending_digits.push_back(exp_req);
				requests_sent <= requests_sent + 1;
				moved = 1'b1;
			end
			if (strobe) begin
				moved = 1'b1;
				got = '{seg_thousands, seg_hundreds, seg_tens, seg_ones, out_of_range};
				if (pending_digits.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("%0t: result with no request waiting: %h %h %h %h oor=%b",
							$realtime, got.th, got.hu, got.te, got.on, got.oor);
				end else begin
					exp_req = pending_digits.pop_front();
					results_checked <= results_checked + 1;
					if (got !== exp_req.want) begin
						fault_count++;
						if (fault_count <= REPORT_LIMIT)
							$display({"%0t: mode %0d value %h: ",
								"want %h %h %h %h oor=%b, got %h %h %h %h oor=%b"},
								$realtime, exp_req.mode, exp_req.value,
								exp_req.want.th, exp_req.want.hu, exp_req.want.te,
								exp_req.want.on, exp_req.want.oor,
								got.th, got.hu, got.te, got.on, got.oor);
					end
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		end
	end

	// Watchdog: end the run when no handshake of any kind happens for too long.
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL number_to_seven_segment_digits");
			$finish;
		end
	end

	// Present one request at the next falling edge and hold it until taken.
	task automatic send_request(logic [15:0] v);
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for a random run of cycles, pct percent chance per cycle.
	task automatic hold_idle(int pct);
		while ($urandom_range(99) < pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Drop start and wait until every expected result has come, then let the pipe settle.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// Write the display mode while nothing is in flight.
	task automatic write_mode(mode_t m);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: reset, directed table, then random segments over every mode and idle profile.
	initial begin
		mode_t m;
		int    count;
		start = 1'b0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_data = MODE_UNSIGNED;
		pin_valid = 1'b0;
		pin_digits = '0;
		requests_sent = 0;
		results_checked = 0;
		mode_writes = 0;
		fault_count = 0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the table; the first rows rely on the mode after reset.
		m = MODE_UNSIGNED;
		for (int r = 0; r < PROBE_COUNT; r++) begin
			if (PROBES[r].mode != m) begin
				m = PROBES[r].mode;
				write_mode(m);
			end
			@(negedge clk);
			pin_valid = PROBES[r].pinned;
			pin_digits = PROBES[r].want;
			start <= 1'b1;
			value <= PROBES[r].value;
			do @(posedge clk); while (busy);
		end
		@(negedge clk);
		pin_valid = 1'b0;
		start <= 1'b0;

		// Random part: three real modes per idle profile, the blank code last.
		for (int s = 0; s < 13; s++) begin
			m = (s == 12) ? MODE_BLANK : mode_t'(s % 3);
			count = (s == 12) ? 50 : 95;
			write_mode(m);
			for (int i = 0; i < count; i++) begin
				hold_idle(IDLE_PCT[s / 3]);
				// now and then, hold off until every result is back
				if ($urandom_range(149) == 0)
					wait_drained();
				send_request(pick_value());
			end
		end

		// Drain, wait out the latency, then look for leftovers.
		wait_drained();
		repeat (2 * PIPE_SETTLE) @(posedge clk);
		if (pending_digits.size() != 0) begin
			fault_count++;
			$display("%0d expected results never arrived", pending_digits.size());
		end

		$display({"Covered %0d requests over unsigned, signed, hex and blank modes ",
			"with %0d mode writes,"}, requests_sent, mode_writes);
		$display("back-to-back and with sender gaps; %0d results checked, %0d failures.",
			results_checked, fault_count);
		if (fault_count == 0) begin
			$display("PASS number_to_seven_segment_digits");
		end else begin
			$display("FAIL number_to_seven_segment_digits");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/nssd_pkg.sv
src/number_to_seven_segment_digits.sv
verif/number_to_seven_segment_digits_tb.sv
